### src/ssas_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the packed SIMD saturating add/subtract unit.
// No dependencies; used by every module of the block.
package ssas_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned MaxLanes = 4;

  typedef enum logic [2:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_HADD = 3'd2,
    KIND_HSUB = 3'd3,
    KIND_ABS  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    LANE_8  = 2'd0,
    LANE_16 = 2'd1,
    LANE_32 = 2'd2
  } lane_size_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic [1:0]        lane_size;
    logic              is_signed;
    logic              saturate;
    logic              round;
    logic [WordW-1:0]  operand_a;
    logic [WordW-1:0]  operand_b;
    logic              clear_sticky;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0]    result;
    logic [MaxLanes-1:0] lane_overflow;
    logic                sticky_overflow;
  } out_beat_t;

  // Per-lane operation controls, common to every lane of a beat.
  typedef struct packed {
    logic [2:0] kind;
    logic       is_signed;
    logic       saturate;
    logic       round;
  } lane_ctrl_t;

endpackage

### src/ssas_lane.sv
`timescale 1ns / 1ps
// One arithmetic lane of width W: add, subtract, halving ops, absolute value,
// with overflow detection and clamping. Depends on ssas_pkg.
module ssas_lane #(
  parameter int unsigned W = 8
) (
  input  ssas_pkg::lane_ctrl_t ctrl_i,
  input  logic [W-1:0]         x_i,
  input  logic [W-1:0]         y_i,
  output logic [W-1:0]         res_o,
  output logic                 ovf_o
);

  // Two guard bits cover unsigned add with rounding and signed abs of min.
  localparam int unsigned X = W + 2;

  logic [X-1:0] xe;
  logic [X-1:0] ye;
  logic [X-1:0] rnd_e;
  logic [X-1:0] v;
  logic [W-1:0] sat_val;
  logic         halving;
  logic         ovf_raw;

  assign xe    = {{2{ctrl_i.is_signed & x_i[W-1]}}, x_i};
  assign ye    = {{2{ctrl_i.is_signed & y_i[W-1]}}, y_i};
  assign rnd_e = {{(X-1){1'b0}}, ctrl_i.round};

  always_comb begin
    case (ctrl_i.kind)
      ssas_pkg::KIND_ADD:  v = xe + ye;
      ssas_pkg::KIND_SUB:  v = xe - ye;
      ssas_pkg::KIND_HADD: v = xe + ye + rnd_e;
      ssas_pkg::KIND_HSUB: v = xe - ye + rnd_e;
      ssas_pkg::KIND_ABS:  v = xe[X-1] ? (~xe + {{(X-1){1'b0}}, 1'b1}) : xe;
      default:             v = '0;
    endcase
  end

  assign halving = (ctrl_i.kind == ssas_pkg::KIND_HADD) ||
                   (ctrl_i.kind == ssas_pkg::KIND_HSUB);

  // Signed: bits above the sign must all match it. Unsigned: no bits set from bit W up.
  always_comb begin
    if (ctrl_i.is_signed) begin
      ovf_raw = !((v[X-1:W-1] == '0) || (v[X-1:W-1] == '1));
      sat_val = v[X-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      ovf_raw = (v[X-1:W] != '0);
      sat_val = v[X-1] ? '0 : '1;
    end
  end

  always_comb begin
    if (halving) begin
      res_o = v[W:1];
      ovf_o = 1'b0;
    end else begin
      res_o = (ovf_raw && ctrl_i.saturate) ? sat_val : v[W-1:0];
      ovf_o = ovf_raw;
    end
  end

endmodule

### src/ssas_alu.sv
`timescale 1ns / 1ps
// Lane array for all three lane sizes and the selection of the packed result.
// Depends on ssas_pkg and ssas_lane.
module ssas_alu (
  input  ssas_pkg::in_beat_t              beat_i,
  output logic [ssas_pkg::WordW-1:0]      result_o,
  output logic [ssas_pkg::MaxLanes-1:0]   lane_ovf_o
);

  ssas_pkg::lane_ctrl_t ctrl;
  logic [31:0] res8;
  logic [31:0] res16;
  logic [31:0] res32;
  logic [3:0]  ovf8;
  logic [1:0]  ovf16;
  logic        ovf32;

  assign ctrl.kind      = beat_i.kind;
  assign ctrl.is_signed = beat_i.is_signed;
  assign ctrl.saturate  = beat_i.saturate;
  assign ctrl.round     = beat_i.round;

  for (genvar i = 0; i < 4; i++) begin : g_l8
    ssas_lane #(.W(8)) u_lane (
      .ctrl_i (ctrl),
      .x_i    (beat_i.operand_a[i*8 +: 8]),
      .y_i    (beat_i.operand_b[i*8 +: 8]),
      .res_o  (res8[i*8 +: 8]),
      .ovf_o  (ovf8[i])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_l16
    ssas_lane #(.W(16)) u_lane (
      .ctrl_i (ctrl),
      .x_i    (beat_i.operand_a[i*16 +: 16]),
      .y_i    (beat_i.operand_b[i*16 +: 16]),
      .res_o  (res16[i*16 +: 16]),
      .ovf_o  (ovf16[i])
    );
  end

  ssas_lane #(.W(32)) u_lane32 (
    .ctrl_i (ctrl),
    .x_i    (beat_i.operand_a),
    .y_i    (beat_i.operand_b),
    .res_o  (res32),
    .ovf_o  (ovf32)
  );

  // Size code 3 falls through to the single 32-bit lane.
  always_comb begin
    unique case (beat_i.lane_size)
      ssas_pkg::LANE_8: begin
        result_o   = res8;
        lane_ovf_o = ovf8;
      end
      ssas_pkg::LANE_16: begin
        result_o   = res16;
        lane_ovf_o = {2'b00, ovf16};
      end
      default: begin
        result_o   = res32;
        lane_ovf_o = {3'b000, ovf32};
      end
    endcase
  end

endmodule

### src/simd_saturating_add_sub.sv
`timescale 1ns / 1ps
// Packed SIMD add/subtract/halving/absolute-value unit with a sticky overflow flag.
// An accepted beat is held in an input register, computed in one pass of lane
// logic and stored in a result register once that register is free. One beat can be
// accepted every cycle; the only limit on throughput is the result register draining,
// with out_ready_i low stalling both stages. The sticky flag is updated in beat order
// as each beat moves into the result register, and each result carries the flag value
// after its own beat.
module simd_saturating_add_sub (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ssas_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssas_pkg::out_beat_t out_data_o
);

  ssas_pkg::in_beat_t  in_q;
  ssas_pkg::out_beat_t out_q;
  ssas_pkg::out_beat_t out_d;
  logic                in_valid_q;
  logic                out_valid_q;
  logic                sticky_q;
  logic                sticky_d;
  logic                in_fire;
  logic                adv;
  logic                out_free;
  logic [ssas_pkg::WordW-1:0]    alu_res;
  logic [ssas_pkg::MaxLanes-1:0] alu_ovf;

  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  ssas_alu u_alu (
    .beat_i     (in_q),
    .result_o   (alu_res),
    .lane_ovf_o (alu_ovf)
  );

  // Clear first, then collect this beat's lane overflows.
  assign sticky_d = (in_q.clear_sticky ? 1'b0 : sticky_q) | (|alu_ovf);

  assign out_d.result          = alu_res;
  assign out_d.lane_overflow   = alu_ovf;
  assign out_d.sticky_overflow = sticky_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sticky_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (adv) begin
        sticky_q <= sticky_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ovf_sets_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.lane_overflow != '0) |-> out_data_o.sticky_overflow)
    else $error("lane overflow delivered without sticky flag");

  a_empty_takes_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("empty input stage refused a beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !adv)
    else $error("stalled result overwritten");

  a_sticky_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sticky_q && !(adv && in_q.clear_sticky) |=> sticky_q)
    else $error("sticky flag dropped without a clear");

endmodule
